FILE: hdl/psc_pkg.sv
package psc_pkg;

    localparam int unsigned RegW    = 32;
    localparam int unsigned IdxW    = 3;
    localparam int unsigned DivW    = 32;
    localparam int unsigned DivBits = 4;

    localparam logic [IdxW-1:0] REG_OSS    = 3'd0;
    localparam logic [IdxW-1:0] REG_AC1AC2 = 3'd1;
    localparam logic [IdxW-1:0] REG_AC3AC4 = 3'd2;
    localparam logic [IdxW-1:0] REG_AC5AC6 = 3'd3;
    localparam logic [IdxW-1:0] REG_B1B2   = 3'd4;
    localparam logic [IdxW-1:0] REG_MCMD   = 3'd5;

    localparam logic [31:0] K_B6_OFFSET = 32'd4000;
    localparam logic [31:0] K_C3038     = 32'd3038;
    localparam logic [31:0] K_CM7357    = 32'hFFFF_E343;
    localparam logic [31:0] K_C3791     = 32'd3791;
    localparam logic [31:0] K_C50000    = 32'd50000;
    localparam logic [31:0] K_C32768    = 32'd32768;
    localparam logic [31:0] K_SIGN      = 32'h8000_0000;

endpackage

FILE: hdl/psc_udiv.sv
module psc_udiv
    import psc_pkg::*;
#(
    parameter int unsigned W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DivW-1:0]   i_num,
    input  logic [DivW-1:0]   i_den,
    input  logic [W-1:0]      i_side,
    output logic              o_valid,
    output logic [DivW-1:0]   o_quo,
    output logic [W-1:0]      o_side
);

    localparam int unsigned NStg = DivW / DivBits;

    logic [DivW-1:0] r_rem  [NStg];
    logic [DivW-1:0] r_num  [NStg];
    logic [DivW-1:0] r_quo  [NStg];
    logic [DivW-1:0] r_den  [NStg];
    logic [W-1:0]    r_side [NStg];
    logic [NStg-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NStg-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < NStg; s++) begin : g_stg
        logic [DivW-1:0] w_rem_in, w_num_in, w_quo_in, w_den_in;
        logic [W-1:0]    w_side_in;
        logic [DivW-1:0] c_rem, c_num, c_quo, c_den;
        logic [DivW:0]   c_trial;
        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_num_in  = i_num;
            assign w_quo_in  = '0;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_num_in  = r_num[s-1];
            assign w_quo_in  = r_quo[s-1];
            assign w_den_in  = r_den[s-1];
            assign w_side_in = r_side[s-1];
        end
        always_comb begin
            c_rem   = w_rem_in;
            c_num   = w_num_in;
            c_quo   = w_quo_in;
            c_den   = w_den_in;
            c_trial = '0;
            for (int k = 0; k < DivBits; k++) begin
                c_trial = {c_rem, c_num[DivW-1]} - {1'b0, c_den};
                c_num   = {c_num[DivW-2:0], 1'b0};
                c_quo   = {c_quo[DivW-2:0], ~c_trial[DivW]};
                if (!c_trial[DivW]) begin
                    c_rem = c_trial[DivW-1:0];
                end else begin
                    c_rem = c_trial[DivW-1:0] + c_den;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= c_rem;
                r_num[s]  <= c_num;
                r_quo[s]  <= c_quo;
                r_den[s]  <= c_den;
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[NStg-1];
    assign o_quo   = r_quo[NStg-1];
    assign o_side  = r_side[NStg-1];

endmodule

FILE: hdl/pressure_sensor_compensation_top.sv
// Channel   Dir  Bits  Fields (lowest bit first)
// s_axis    in   40    tdata: raw_temperature[15:0], raw_pressure[34:16]
// m_axis    out  64+1  tdata: temperature_tenths[31:0], pressure_pascal[63:32]; tuser: status
// cfg       in   32    oversampling_mode, coefficient words by index 0..5
// One request enters per cycle while the output buffer is not full; its result passes through
// the arithmetic stages, two 8-stage dividers (four quotient bits per stage) in series and
// the output register.
// Reset clears all valid bits and the configuration registers.
// A stall freezes the whole pipeline; a two-entry output buffer lets one more result
// land while the first waits, so tready depends only on registered state.
module pressure_sensor_compensation_top
    import psc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // raw_temperature, raw_pressure
    input  logic [39:0]      s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // temperature_tenths, pressure_pascal
    output logic [63:0]      m_axis_tdata,
    // status
    output logic             m_axis_tuser,
    input  logic             i_cfg_we,
    input  logic [IdxW-1:0]  i_cfg_idx,
    input  logic [RegW-1:0]  i_cfg_data
);

    logic [1:0]  r_oss;
    logic [31:0] r_c1, r_c2, r_c3, r_c4, r_c5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss <= '0;
            r_c1  <= '0;
            r_c2  <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            r_c5  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OSS:    r_oss <= i_cfg_data[1:0];
                REG_AC1AC2: r_c1  <= i_cfg_data;
                REG_AC3AC4: r_c2  <= i_cfg_data;
                REG_AC5AC6: r_c3  <= i_cfg_data;
                REG_B1B2:   r_c4  <= i_cfg_data;
                REG_MCMD:   r_c5  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{r_c1[31]}}, r_c1[31:16]};
    assign ac2 = {{16{r_c1[15]}}, r_c1[15:0]};
    assign ac3 = {{16{r_c2[31]}}, r_c2[31:16]};
    assign ac4 = {16'd0, r_c2[15:0]};
    assign ac5 = {16'd0, r_c3[31:16]};
    assign ac6 = {16'd0, r_c3[15:0]};
    assign b1  = {{16{r_c4[31]}}, r_c4[31:16]};
    assign b2  = {{16{r_c4[15]}}, r_c4[15:0]};
    assign mc  = {{16{r_c5[31]}}, r_c5[31:16]};
    assign md  = {{16{r_c5[15]}}, r_c5[15:0]};

    // Output skid buffer and pipeline enable.
    logic        w_en;
    logic [1:0]  r_cnt;
    logic [64:0] r_q0, r_q1;
    logic        w_out_v;
    logic [64:0] w_out_d;
    logic        w_push, w_pop;

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    // Stage A: x1 = asr((ut - ac6) * ac5, 15).
    logic        r_a_v;
    logic [31:0] r_a_prod;
    logic [18:0] r_a_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= s_axis_tvalid;
        end
        if (w_en) begin
            r_a_prod <= ({16'd0, s_axis_tdata[15:0]} - ac6) * ac5;
            r_a_up   <= s_axis_tdata[34:16];
        end
    end

    // Stage B: temperature divisor and signs.
    logic [31:0] w_b_x1, w_b_div, w_b_num;
    assign w_b_x1  = $signed(r_a_prod) >>> 15;
    assign w_b_div = w_b_x1 + md;
    assign w_b_num = mc << 11;

    logic        r_b_v, r_b_zero, r_b_neg;
    logic [31:0] r_b_x1, r_b_mnum, r_b_mden;
    logic [18:0] r_b_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
        if (w_en) begin
            r_b_x1   <= w_b_x1;
            r_b_zero <= (w_b_div == 32'd0);
            r_b_neg  <= w_b_num[31] ^ w_b_div[31];
            r_b_mnum <= w_b_num[31] ? (32'd0 - w_b_num) : w_b_num;
            r_b_mden <= w_b_div[31] ? (32'd0 - w_b_div) : w_b_div;
            r_b_up   <= r_a_up;
        end
    end

    localparam int unsigned S1W = 32 + 1 + 1 + 19;
    logic           w_d1_v;
    logic [31:0]    w_d1_q;
    logic [S1W-1:0] w_d1_s;
    psc_udiv #(.W(S1W)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_v),
        .i_num   (r_b_mnum),
        .i_den   (r_b_zero ? 32'd1 : r_b_mden),
        .i_side  ({r_b_x1, r_b_zero, r_b_neg, r_b_up}),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_s)
    );

    // Stage C: b5, t, b6.
    logic [31:0] w_c_x2, w_c_b5;
    assign w_c_x2 = w_d1_s[19] ? (32'd0 - w_d1_q) : w_d1_q;
    assign w_c_b5 = w_d1_s[52:21] + w_c_x2;

    logic        r_c_v, r_c_zero;
    logic [31:0] r_c_t, r_c_b6;
    logic [18:0] r_c_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= w_d1_v;
        end
        if (w_en) begin
            r_c_t    <= $signed(w_c_b5 + 32'd8) >>> 4;
            r_c_b6   <= w_c_b5 - K_B6_OFFSET;
            r_c_zero <= w_d1_s[20];
            r_c_up   <= w_d1_s[18:0];
        end
    end

    // Stage D: b6 squared, ac2*b6, ac3*b6.
    logic        r_d_v, r_d_zero;
    logic [31:0] r_d_t, r_d_sqp, r_d_p2, r_d_p3;
    logic [18:0] r_d_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_d_v <= r_c_v;
        end
        if (w_en) begin
            r_d_t    <= r_c_t;
            r_d_zero <= r_c_zero;
            r_d_up   <= r_c_up;
            r_d_sqp  <= r_c_b6 * r_c_b6;
            r_d_p2   <= ac2 * r_c_b6;
            r_d_p3   <= ac3 * r_c_b6;
        end
    end

    // Stage E: b2*sq, b1*sq.
    logic [31:0] w_e_sq;
    assign w_e_sq = $signed(r_d_sqp) >>> 12;
    logic        r_e_v, r_e_zero;
    logic [31:0] r_e_t, r_e_p2, r_e_p3, r_e_q2, r_e_q1;
    logic [18:0] r_e_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= r_d_v;
        end
        if (w_en) begin
            r_e_t    <= r_d_t;
            r_e_zero <= r_d_zero;
            r_e_up   <= r_d_up;
            r_e_p2   <= r_d_p2;
            r_e_p3   <= r_d_p3;
            r_e_q2   <= b2 * w_e_sq;
            r_e_q1   <= b1 * w_e_sq;
        end
    end

    // Stage F: b3 and the b4 factor.
    logic [31:0] w_f_x3, w_f_num, w_f_b3, w_f_a, w_f_b, w_f_x3b;
    assign w_f_x3  = ($signed(r_e_q2) >>> 11) + ($signed(r_e_p2) >>> 11);
    assign w_f_num = ((ac1 * 32'd4 + w_f_x3) << r_oss) + 32'd2;
    assign w_f_b3  = w_f_num[31] ? (32'd0 - ((32'd0 - w_f_num) >> 2))
                                 : (w_f_num >> 2);
    assign w_f_a   = $signed(r_e_p3) >>> 13;
    assign w_f_b   = $signed(r_e_q1) >>> 16;
    assign w_f_x3b = $signed(w_f_a + w_f_b + 32'd2) >>> 2;
    logic        r_f_v, r_f_zero;
    logic [31:0] r_f_t, r_f_b3, r_f_x3;
    logic [18:0] r_f_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= r_e_v;
        end
        if (w_en) begin
            r_f_t    <= r_e_t;
            r_f_zero <= r_e_zero;
            r_f_up   <= r_e_up;
            r_f_b3   <= w_f_b3;
            r_f_x3   <= w_f_x3b + K_C32768;
        end
    end

    // Stage G: b4 and b7 products.
    logic [31:0] w_g_b4p;
    assign w_g_b4p = ac4 * r_f_x3;
    logic        r_g_v, r_g_zero;
    logic [31:0] r_g_t, r_g_b4, r_g_b7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v <= r_f_v;
        end
        if (w_en) begin
            r_g_t    <= r_f_t;
            r_g_zero <= r_f_zero;
            r_g_b4   <= w_g_b4p >> 15;
            r_g_b7   <= ({13'd0, r_f_up} - r_f_b3) * (K_C50000 >> r_oss);
        end
    end

    logic w_h_zero, w_h_big;
    assign w_h_zero = r_g_zero || (r_g_b4 == 32'd0);
    assign w_h_big  = (r_g_b7 >= K_SIGN);

    localparam int unsigned S2W = 32 + 1 + 1;
    logic           w_d2_v;
    logic [31:0]    w_d2_q;
    logic [S2W-1:0] w_d2_s;
    psc_udiv #(.W(S2W)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_v),
        .i_num   (w_h_big ? r_g_b7 : (r_g_b7 << 1)),
        .i_den   (w_h_zero ? 32'd1 : r_g_b4),
        .i_side  ({r_g_t, w_h_zero, w_h_big}),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_q),
        .o_side  (w_d2_s)
    );

    // Stage I: p and the correction products.
    logic [31:0] w_i_p, w_i_ps;
    assign w_i_p  = w_d2_s[0] ? (w_d2_q << 1) : w_d2_q;
    assign w_i_ps = $signed(w_i_p) >>> 8;
    logic        r_i_v, r_i_zero;
    logic [31:0] r_i_t, r_i_p, r_i_sq, r_i_m2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (w_en) begin
            r_i_v <= w_d2_v;
        end
        if (w_en) begin
            r_i_t    <= w_d2_s[33:2];
            r_i_zero <= w_d2_s[1];
            r_i_p    <= w_i_p;
            r_i_sq   <= w_i_ps * w_i_ps;
            r_i_m2   <= K_CM7357 * w_i_p;
        end
    end

    // Stage J: x1 * 3038.
    logic        r_j_v, r_j_zero;
    logic [31:0] r_j_t, r_j_p, r_j_m1, r_j_m2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (w_en) begin
            r_j_v <= r_i_v;
        end
        if (w_en) begin
            r_j_t    <= r_i_t;
            r_j_zero <= r_i_zero;
            r_j_p    <= r_i_p;
            r_j_m1   <= r_i_sq * K_C3038;
            r_j_m2   <= r_i_m2;
        end
    end

    logic [31:0] w_k_a, w_k_b, w_k_sum, w_k_c, w_k_p;
    assign w_k_a   = $signed(r_j_m1) >>> 16;
    assign w_k_b   = $signed(r_j_m2) >>> 16;
    assign w_k_sum = w_k_a + w_k_b + K_C3791;
    assign w_k_c   = $signed(w_k_sum) >>> 4;
    assign w_k_p   = r_j_p + w_k_c;

    assign w_out_v = r_j_v;
    assign w_out_d = r_j_zero ? {1'b1, 64'd0} : {1'b0, w_k_p, r_j_t};

    // Skid: up to two results are held while the downstream side stalls.
    assign w_push = w_en && w_out_v;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (w_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop))) begin
            r_q0 <= w_out_d;
        end else if (w_pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
        if (w_push && r_cnt == 2'd1 && !w_pop) begin
            r_q1 <= w_out_d;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q0[63:0];
    assign m_axis_tuser  = r_q0[64];

    property p_cnt_max;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_cnt_max: assert property (p_cnt_max) else $error("skid overflow");

    property p_stall_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid;
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("result lost");

    property p_zero_status;
        @(posedge i_clk) disable iff (!i_rst_n)
            (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0);
    endproperty
    a_zero_status: assert property (p_zero_status) else $error("refused not zero");

endmodule

FILE: tb/pressure_sensor_compensation_top_tb.sv
module pressure_sensor_compensation_top_tb
    import psc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [18:0] up;
        logic [15:0] ut;
    } t_raw;

    typedef struct packed {
        logic        status;
        logic [31:0] pres;
        logic [31:0] temp;
    } t_comp;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    logic [IdxW-1:0]   i_cfg_idx = '0;
    logic [RegW-1:0]   i_cfg_data = '0;

    pressure_sensor_compensation_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [1:0]  oss_q;
    logic [31:0] cal_q [1:5];
    t_raw        pending_raw [$];
    t_comp       expected_comp [$];
    int          n_fail = 0;
    int          n_checked = 0;
    int          n_refused = 0;
    int          cycle_cnt = 0;
    bit          allow_idle = 1'b1;
    bit          src_acc = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    function automatic logic [31:0] sx16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] quot_tz(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_comp compensate(input t_raw r);
        t_comp c;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, dv, b5, t, b6, sq, b3, b4, b7, p;
        c = '{status: 1'b1, pres: '0, temp: '0};
        ac1 = sx16(cal_q[1][31:16]); ac2 = sx16(cal_q[1][15:0]);
        ac3 = sx16(cal_q[2][31:16]); ac4 = {16'd0, cal_q[2][15:0]};
        ac5 = {16'd0, cal_q[3][31:16]}; ac6 = {16'd0, cal_q[3][15:0]};
        b1 = sx16(cal_q[4][31:16]); b2 = sx16(cal_q[4][15:0]);
        mc = sx16(cal_q[5][31:16]); md = sx16(cal_q[5][15:0]);
        x1 = asr(({16'd0, r.ut} - ac6) * ac5, 15);
        dv = x1 + md;
        if (dv == 0) return c;
        x2 = quot_tz(mc << 11, dv);
        b5 = x1 + x2;
        t = asr(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = quot_tz(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 32'd4);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return c;
        b7 = ({13'd0, r.up} - b3) * (32'd50000 >> oss_q);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr(32'hFFFF_E343 * p, 16);
        p = p + asr(x1 + x2 + 32'd3791, 4);
        c.status = 1'b0;
        c.temp = t;
        c.pres = p;
        return c;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 600000) begin
            $display("FAIL pressure_sensor_compensation_top");
            $finish;
        end
    end

    // Driver: present a request at the falling edge and hold it until accepted.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || src_acc) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_raw.size() > 0) begin
                    if (allow_idle && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(0, 13);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata <= {5'd0, pending_raw[0]};
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        t_comp got, want;
        src_acc = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                src_acc = 1'b1;
                expected_comp.push_back(compensate(t_raw'(s_axis_tdata[34:0])));
                void'(pending_raw.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_comp'({m_axis_tuser, m_axis_tdata});
                if (expected_comp.size() == 0) begin
                    $error("result with no request outstanding");
                    n_fail++;
                end else begin
                    want = expected_comp.pop_front();
                    n_checked++;
                    if (want.status) n_refused++;
                    if (got.temp !== want.temp) begin
                        $error("temperature_tenths exp %0d got %0d",
                               $signed(want.temp), $signed(got.temp));
                        n_fail++;
                    end
                    if (got.pres !== want.pres) begin
                        $error("pressure_pascal exp %0d got %0d",
                               $signed(want.pres), $signed(got.pres));
                        n_fail++;
                    end
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        n_fail++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_OSS) oss_q = val[1:0];
        else if (idx <= REG_MCMD) cal_q[idx] = val;
    endtask

    task automatic drain();
        while (pending_raw.size() > 0 || expected_comp.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [1:0] oss, input logic [31:0] w1, input logic [31:0] w2,
                            input logic [31:0] w3, input logic [31:0] w4, input logic [31:0] w5);
        write_reg(REG_OSS, {30'd0, oss});
        write_reg(REG_AC1AC2, w1);
        write_reg(REG_AC3AC4, w2);
        write_reg(REG_AC5AC6, w3);
        write_reg(REG_B1B2, w4);
        write_reg(REG_MCMD, w5);
    endtask

    function automatic t_raw rand_raw();
        t_raw r;
        r.ut = 16'($urandom);
        r.up = 19'($urandom);
        return r;
    endfunction

    initial begin
        oss_q = '0;
        for (int k = 1; k <= 5; k++) cal_q[k] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // All-zero calibration refuses everything.
        pending_raw.push_back('{up: 19'h7FFFF, ut: 16'hFFFF});
        pending_raw.push_back('{up: 19'd0, ut: 16'd0});
        drain();
        // Typical datasheet calibration.
        load_cal(2'd0, {16'd408, 16'hFFB8}, {16'hC3AD, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {16'hD4BD, 16'd2868});
        pending_raw.push_back('{up: 19'd23843, ut: 16'd27898});
        pending_raw.push_back('{up: 19'h7FFFF, ut: 16'hFFFF});
        pending_raw.push_back('{up: 19'd0, ut: 16'd0});
        pending_raw.push_back('{up: 19'd1, ut: 16'h8000});
        drain();
        for (int m = 1; m <= 3; m++) begin
            write_reg(REG_OSS, m);
            pending_raw.push_back('{up: 19'd23843 << m, ut: 16'd27898});
            pending_raw.push_back('{up: 19'h7FFFF, ut: 16'd0});
            drain();
        end
        // Temperature divisor zero: ac5 = 0 so x1 = 0, md = 0.
        load_cal(2'd1, 32'h1234_5678, 32'h0001_0001, 32'h0000_0001, 32'h0001_0001, 32'h0100_0000);
        pending_raw.push_back('{up: 19'd100, ut: 16'd5});
        drain();
        // Pressure divisor zero: ac4 = 0; then extreme words with division overflow.
        load_cal(2'd3, 32'h7FFF_8000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_8000, 32'h8000_0001);
        pending_raw.push_back('{up: 19'd77, ut: 16'd1});
        drain();
        load_cal(2'd2, 32'h8000_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_7FFF, 32'h7FFF_FFFF);
        write_reg(3'd7, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++) pending_raw.push_back(rand_raw());
        drain();
        // Random phases, alternating between random words and near-typical calibration.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 2 == 0) begin
                load_cal(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                load_cal(2'($urandom),
                         {16'($urandom_range(0, 9000)), 16'($urandom_range(0, 400) - 200)},
                         {16'($urandom_range(0, 30000) - 15000), 16'($urandom_range(20000, 40000))},
                         {16'($urandom_range(20000, 40000)), 16'($urandom_range(10000, 30000))},
                         {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 40))},
                         {16'($urandom_range(0, 20000) - 20000), 16'($urandom_range(1000, 4000))});
            end
            if (ph == 6) allow_idle = 1'b0;
            for (int k = 0; k < 105; k++) pending_raw.push_back(rand_raw());
            drain();
        end
        $display("Checked %0d results, %0d of them refused, over all oversampling modes.",
                 n_checked, n_refused);
        if (n_fail == 0) begin
            $display("PASS pressure_sensor_compensation_top");
        end else begin
            $display("FAIL pressure_sensor_compensation_top");
        end
        $finish;
    end
endmodule

FILE: pressure_sensor_compensation_top.f
hdl/psc_pkg.sv
hdl/psc_udiv.sv
hdl/pressure_sensor_compensation_top.sv
tb/pressure_sensor_compensation_top_tb.sv
